/* rtl/core/ffra_pkg.sv */
// Package of the first-fit range allocator: shared widths, codes and the
// structs that run between the controller and the chain of table cells.
// No dependencies.
package ffra_pkg;

	localparam int MAX_RANGES_DEF = 16;
	localparam int ADDR_BITS_DEF  = 32;
	// Holders wide enough for any supported ADDR_BITS and for grown lengths.
	localparam int WW    = 64;
	// Index holders cover the largest supported table of 256 entries.
	localparam int IDX_W = 8;
	localparam logic [31:0] BLOCK_SIZE_RST = 32'd67108864;

	localparam logic CFG_BLOCK_SIZE = 1'b0;
	localparam logic CFG_DEDICATED  = 1'b1;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOFIT     = 2'd1,
		ST_DEDICATED = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CMT_NONE, CMT_INIT, CMT_DED, CMT_ALLOC, CMT_FREE
	} cmt_kind_t;

	// Request operands broadcast to every cell during a scan.
	typedef struct packed {
		logic            op;
		logic [WW-1:0]   amount;
		logic [WW-1:0]   am1;
		logic [WW-1:0]   off;
		logic [WW-1:0]   fend;
	} req_t;

	// Search token handed from cell to cell.
	typedef struct packed {
		logic             go;
		logic             found;
		logic [IDX_W-1:0] best_i;
		logic [WW-1:0]    lo;
		logic [WW-1:0]    al;
		logic [WW-1:0]    gr;
		logic             same_f;
		logic [IDX_W-1:0] same_i;
		logic             below_f;
		logic [IDX_W-1:0] below_i;
		logic             above_f;
		logic [IDX_W-1:0] above_i;
		logic [WW-1:0]    above_len;
		logic             slot_f;
		logic [IDX_W-1:0] slot_i;
	} tok_t;

	// Table update broadcast to every cell in the cycle it takes effect.
	typedef struct packed {
		cmt_kind_t        kind;
		logic [WW-1:0]    init_len;
		logic [IDX_W-1:0] best_i;
		logic [WW-1:0]    grant;
		logic             same_f;
		logic [IDX_W-1:0] same_i;
		logic             below_f;
		logic [IDX_W-1:0] below_i;
		logic             above_f;
		logic [IDX_W-1:0] above_i;
		logic [IDX_W-1:0] slot_i;
		logic [WW-1:0]    off;
		logic [WW-1:0]    size;
		logic [WW-1:0]    add_len;
	} cmt_t;

endpackage

/* rtl/core/ffra_cell.sv */
// One entry of the free-range table with its stage of the search chain.
// Depends on ffra_pkg.
module ffra_cell #(
	parameter int IDX       = 0,
	parameter int ADDR_BITS = ffra_pkg::ADDR_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ffra_pkg::req_t req,
	input  ffra_pkg::cmt_t cmt,
	input  ffra_pkg::tok_t tok_in,
	output ffra_pkg::tok_t tok_out
);

	localparam logic [ffra_pkg::WW-1:0] AMASK =
		(ffra_pkg::WW'(1) << ADDR_BITS) - ffra_pkg::WW'(1);
	localparam logic [ffra_pkg::WW-1:0] RST_LEN =
		(IDX == 0) ? (ffra_pkg::WW'(ffra_pkg::BLOCK_SIZE_RST) & AMASK) : '0;
	localparam logic [ffra_pkg::IDX_W-1:0] MY = ffra_pkg::IDX_W'(IDX);

	logic [ADDR_BITS-1:0]    begin_q;
	logic [ffra_pkg::WW-1:0] len_q;
	logic                    valid_q;
	ffra_pkg::tok_t          t;
	logic [ffra_pkg::WW-1:0] lo, al, gr;

	always_comb begin
		lo = ffra_pkg::WW'(begin_q);
		al = (lo + req.am1) & ~req.am1;
		gr = req.amount + (al - lo);
		t  = tok_in;
		if (tok_in.go) begin
			if (req.op == ffra_pkg::OP_ALLOC) begin
				if (valid_q && len_q >= gr && (!tok_in.found || lo < tok_in.lo)) begin
					t.found  = 1'b1;
					t.best_i = MY;
					t.lo     = lo;
					t.al     = al;
					t.gr     = gr;
				end
			end else if (!valid_q) begin
				if (!tok_in.slot_f) begin
					t.slot_f = 1'b1;
					t.slot_i = MY;
				end
			end else if (lo == req.off) begin
				t.same_f = 1'b1;
				t.same_i = MY;
			end else if (lo + len_q == req.off && !tok_in.below_f) begin
				t.below_f = 1'b1;
				t.below_i = MY;
			end else if (lo == req.fend && !tok_in.above_f) begin
				t.above_f   = 1'b1;
				t.above_i   = MY;
				t.above_len = len_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
			begin_q <= '0;
			len_q   <= RST_LEN;
			valid_q <= (RST_LEN != '0);
		end else begin
			tok_out <= t;
			case (cmt.kind)
				ffra_pkg::CMT_INIT: begin
					begin_q <= '0;
					len_q   <= (IDX == 0) ? cmt.init_len : '0;
					valid_q <= (IDX == 0) && (cmt.init_len != '0);
				end
				ffra_pkg::CMT_DED: begin
					valid_q <= 1'b0;
				end
				ffra_pkg::CMT_ALLOC: begin
					if (cmt.best_i == MY) begin
						if (len_q > cmt.grant) begin
							begin_q <= ADDR_BITS'(ffra_pkg::WW'(begin_q) + cmt.grant);
							len_q   <= len_q - cmt.grant;
						end else begin
							valid_q <= 1'b0;
						end
					end
				end
				ffra_pkg::CMT_FREE: begin
					// A matching start is dropped when a neighbor absorbs the range;
					// otherwise the same entry is rewritten as the new range below.
					if (cmt.same_f && cmt.same_i == MY && (cmt.below_f || cmt.above_f))
						valid_q <= 1'b0;
					if (cmt.below_f) begin
						if (cmt.below_i == MY)
							len_q <= len_q + cmt.add_len;
						if (cmt.above_f && cmt.above_i == MY)
							valid_q <= 1'b0;
					end else if (cmt.above_f) begin
						if (cmt.above_i == MY) begin
							begin_q <= ADDR_BITS'(cmt.off);
							len_q   <= len_q + cmt.size;
						end
					end else if (cmt.slot_i == MY) begin
						begin_q <= ADDR_BITS'(cmt.off);
						len_q   <= cmt.size;
						valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/first_fit_range_allocator_unit.sv */
// Top level of the first-fit range allocator: controller, result register
// and the chain of table cells. Depends on ffra_pkg and ffra_cell.
//
// The block keeps the free ranges of one memory block in a row of
// MAX_RANGES cells, one range per cell. Every request, allocate or free,
// launches a search token into the first cell; the token moves one cell
// per clock and collects the first fit (allocate) or the neighbors and the
// first empty slot (free). When it leaves the last cell the controller
// decides the outcome, broadcasts the table update to all cells in the
// same cycle and loads the result register. The next input is taken
// only once the result transaction completes, so one transaction is in
// flight at a time. A configuration write of block_size reinitializes
// the table; writes are taken at any time but are meant for an idle
// block.
module first_fit_range_allocator_unit #(
	parameter int MAX_RANGES = ffra_pkg::MAX_RANGES_DEF,
	parameter int ADDR_BITS  = ffra_pkg::ADDR_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// request_size[31:0], align_log2[36:32], free_offset[68:37],
	// free_size[100:69], zero fill above
	input  logic [103:0] s_tdata,
	// opcode[0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// range_start[31:0], aligned_offset[63:32], granted_size[95:64],
	// bytes_in_use[127:96]
	output logic [127:0] m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int WW = ffra_pkg::WW;
	localparam logic [WW-1:0] AMASK = (WW'(1) << ADDR_BITS) - WW'(1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

	state_t          state_q;
	logic            start_q;
	logic            op_q;
	logic [WW-1:0]   amount_q, off_q, size_q;
	logic [4:0]      alog_q;
	logic [31:0]     bs_q;
	logic            ded_q;
	logic [31:0]     used_q;
	logic            whole_q;
	ffra_pkg::status_t st_q;
	logic [31:0]     rs_q, ao_q, gs_q;

	ffra_pkg::req_t  req;
	ffra_pkg::cmt_t  cmt;
	ffra_pkg::tok_t  tok [MAX_RANGES+1];
	ffra_pkg::tok_t  t;
	logic            s_acc, cfg_acc, done;
	logic [WW-1:0]   bs_m;
	ffra_pkg::status_t st_d;
	logic [31:0]     rs_d, ao_d, gs_d, used_d;
	logic            whole_d;

	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = (state_q == S_OUT);
	assign cfg_ready = 1'b1;
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign m_tdata   = {used_q, gs_q, ao_q, rs_q};
	assign m_tuser   = st_q;

	assign bs_m = WW'(bs_q) & AMASK;

	always_comb begin
		req.op     = op_q;
		req.amount = amount_q;
		req.am1    = (WW'(1) << alog_q) - WW'(1);
		req.off    = off_q;
		req.fend   = off_q + size_q;
	end

	assign tok[0] = '{go: start_q, default: '0};

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		ffra_cell #(.IDX(i), .ADDR_BITS(ADDR_BITS)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.req     (req),
			.cmt     (cmt),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	assign t    = tok[MAX_RANGES];
	assign done = (state_q == S_SCAN) && t.go;

	// Outcome of the finished search and the table update it implies.
	always_comb begin
		cmt      = '0;
		cmt.kind = ffra_pkg::CMT_NONE;
		st_d     = ffra_pkg::ST_OK;
		rs_d     = '0;
		ao_d     = '0;
		gs_d     = '0;
		used_d   = used_q;
		whole_d  = whole_q;
		if (op_q == ffra_pkg::OP_ALLOC) begin
			if (ded_q) begin
				if (!whole_q && amount_q == bs_m) begin
					cmt.kind = ffra_pkg::CMT_DED;
					gs_d     = amount_q[31:0];
					used_d   = used_q + amount_q[31:0];
					whole_d  = 1'b1;
				end else begin
					st_d = ffra_pkg::ST_DEDICATED;
				end
			end else if (t.found) begin
				cmt.kind   = ffra_pkg::CMT_ALLOC;
				cmt.best_i = t.best_i;
				cmt.grant  = t.gr;
				rs_d       = t.lo[31:0];
				ao_d       = t.al[31:0];
				gs_d       = t.gr[31:0];
				used_d     = used_q + t.gr[31:0];
			end else begin
				st_d = ffra_pkg::ST_NOFIT;
			end
		end else if (size_q != '0) begin
			if (!t.below_f && !t.above_f && !t.slot_f && !t.same_f) begin
				st_d = ffra_pkg::ST_FULL;
			end else begin
				cmt.kind    = ffra_pkg::CMT_FREE;
				cmt.same_f  = t.same_f;
				cmt.same_i  = t.same_i;
				cmt.below_f = t.below_f;
				cmt.below_i = t.below_i;
				cmt.above_f = t.above_f;
				cmt.above_i = t.above_i;
				cmt.slot_i  = t.same_f ? t.same_i : t.slot_i;
				cmt.off     = off_q;
				cmt.size    = size_q;
				cmt.add_len = size_q + (t.above_f ? t.above_len : '0);
				used_d      = used_q - size_q[31:0];
				whole_d     = 1'b0;
			end
		end
		if (!done) begin
			cmt      = '0;
			cmt.kind = ffra_pkg::CMT_NONE;
		end
		// A block_size write rebuilds the table as at reset.
		if (cfg_acc && cfg_index == ffra_pkg::CFG_BLOCK_SIZE) begin
			cmt          = '0;
			cmt.kind     = ffra_pkg::CMT_INIT;
			cmt.init_len = WW'(cfg_data) & AMASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
			bs_q    <= ffra_pkg::BLOCK_SIZE_RST;
			ded_q   <= 1'b0;
			used_q  <= '0;
			whole_q <= 1'b0;
			st_q    <= ffra_pkg::ST_OK;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						start_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (done) begin
						st_q    <= st_d;
						used_q  <= used_d;
						whole_q <= whole_d;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_acc) begin
				if (cfg_index == ffra_pkg::CFG_BLOCK_SIZE) begin
					bs_q    <= cfg_data;
					used_q  <= '0;
					whole_q <= 1'b0;
				end else begin
					ded_q <= cfg_data[0];
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q     <= s_tuser[0];
			amount_q <= WW'(s_tdata[31:0]) & AMASK;
			alog_q   <= s_tdata[36:32];
			off_q    <= WW'(s_tdata[68:37]) & AMASK;
			size_q   <= WW'(s_tdata[100:69]) & AMASK;
		end
		if (done) begin
			rs_q <= rs_d;
			ao_q <= ao_d;
			gs_q <= gs_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_tvalid)
		else $error("finished search did not present a result");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> (!s_tready && start_q))
		else $error("accepted request did not launch a search");
	a_commit_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmt.kind == ffra_pkg::CMT_ALLOC || cmt.kind == ffra_pkg::CMT_FREE ||
		 cmt.kind == ffra_pkg::CMT_DED) |-> (state_q == S_SCAN))
		else $error("table update outside a finished search");
`endif

endmodule
